[rtl/ffha_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Field widths, header entry layout, request and status codes, sequencer
// states and the header store request bundle.
// ----------------------------------------------------------------------------
package ffha_pkg;

	// fixed field widths
	localparam int SIZE_W  = 17;
	localparam int ADDR_W  = 16;
	localparam int LIMIT_W = 17;
	// internal byte offset width, wide enough for sums past the heap end
	localparam int OFF_W   = 19;
	// header entry: in-use mark over a 17-bit payload size
	localparam int ENTRY_W = SIZE_W + 1;

	localparam int ALIGN_BYTES = 8;
	localparam int ALIGN_W     = $clog2(ALIGN_BYTES);

	localparam int HEAP_BYTES_DEF   = 65536;
	localparam int HEADER_BYTES_DEF = 32;
	// the heap end never passes 64 KiB, so no header lives beyond it
	localparam int MAX_STORE_BYTES  = 65536;
	// largest limit the 17-bit register can express
	localparam int LIMIT_MAX        = 131071;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK           = 2'd0,
		STAT_ZERO_SIZE    = 2'd1,
		STAT_NO_MEM       = 2'd2,
		STAT_FREE_IGNORED = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ALLOC_START,
		ST_ALLOC_PREP,
		ST_WALK_CHK,
		ST_WALK_RD,
		ST_SPLIT_ADDR,
		ST_SPLIT_WR,
		ST_APPEND_CHK,
		ST_APPEND_PAY,
		ST_FREE_START,
		ST_FREE_HDR,
		ST_FREE_CHK,
		ST_FREE_NXT,
		ST_FREE_ACC,
		ST_FREE_WR,
		ST_DONE
	} state_t;

	// header store access, byte offsets (slot = offset / ALIGN_BYTES)
	typedef struct packed {
		logic               rd_en;
		logic [OFF_W-1:0]   rd_off;
		logic               wr_en;
		logic [OFF_W-1:0]   wr_off;
		logic [ENTRY_W-1:0] wr_data;
	} hdr_req_t;

endpackage : ffha_pkg
`default_nettype wire

[rtl/ffha_hdr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_hdr_ram: block header store
// One entry per aligned slot of the heap; one write and one registered read
// per cycle. Contents are undefined until written.
// ----------------------------------------------------------------------------
module ffha_hdr_ram
	import ffha_pkg::*;
#(
	parameter int SLOTS = MAX_STORE_BYTES / ALIGN_BYTES
) (
	input  wire logic               clk,
	input  wire hdr_req_t           req,
	output      logic [ENTRY_W-1:0] rd_data
);

	localparam int IDX_W = $clog2(SLOTS);

	logic [ENTRY_W-1:0] mem_q [SLOTS];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;

	assign rd_idx  = req.rd_off[ALIGN_W +: IDX_W];
	assign wr_idx  = req.wr_off[ALIGN_W +: IDX_W];
	assign rd_data = rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wr_idx] <= req.wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

endmodule : ffha_hdr_ram
`default_nettype wire

[rtl/ffha_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_seq: allocator sequencer and shared add/subtract unit
// Walks the implicit block list for allocate, merges following free blocks
// for free, and keeps the heap end. Every sum goes through one adder.
// ----------------------------------------------------------------------------
module ffha_seq
	import ffha_pkg::*;
#(
	parameter int HDR_SPAN    = HEADER_BYTES_DEF,
	parameter int STORE_BYTES = MAX_STORE_BYTES,
	parameter int HEAP_LIM    = HEAP_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request word
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire op_t                op,
	input  wire logic [SIZE_W-1:0]  size,
	input  wire logic [ADDR_W-1:0]  addr,
	// limit register
	input  wire logic [LIMIT_W-1:0] heap_limit,
	// header store
	output      hdr_req_t           hdr_req,
	input  wire logic [ENTRY_W-1:0] hdr_rd_data,
	// result word
	output      logic               res_valid,
	input  wire logic               res_ready,
	output      logic [ADDR_W-1:0]  res_paddr,
	output      status_t            res_status
);

	localparam logic [OFF_W-1:0]   SPAN      = OFF_W'(HDR_SPAN);
	localparam logic [OFF_W-1:0]   STORE_END = OFF_W'(STORE_BYTES);
	localparam logic [OFF_W-1:0]   ROUND_ADD = OFF_W'(ALIGN_BYTES - 1);
	localparam logic [LIMIT_W-1:0] LIM_CAP   = LIMIT_W'(HEAP_LIM);

	state_t state_q, state_d;

	// request and work registers
	logic [SIZE_W-1:0]  size_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [OFF_W-1:0]   n_q;         // rounded request
	logic [OFF_W-1:0]   nspan_q;     // rounded request plus header span
	logic [OFF_W-1:0]   cur_q;       // header offset under test
	logic [OFF_W-1:0]   pay_q;       // payload offset of cur_q
	logic [SIZE_W-1:0]  ps_q;        // payload size of the fitting block
	logic [OFF_W-1:0]   split_off_q; // header offset of split remainder
	logic [OFF_W-1:0]   new_end_q;
	logic [OFF_W-1:0]   hdr_off_q;   // header being freed
	logic [OFF_W-1:0]   adj_q;       // next header after the merged run
	logic [SIZE_W-1:0]  sz_q;
	logic [LIMIT_W-1:0] heap_end_q;
	logic [ADDR_W-1:0]  res_paddr_q;
	status_t            res_status_q;

	// shared adder
	logic [OFF_W-1:0] alu_a, alu_b, alu_res;
	logic             alu_sub;

	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + OFF_W'(alu_sub);

	// decoded header entry and compares
	logic              rd_used;
	logic [SIZE_W-1:0] rd_size;
	logic [OFF_W-1:0]  rd_size_x;
	logic [OFF_W-1:0]  heap_end_x;
	logic [LIMIT_W-1:0] lim;
	logic              fit, split, free_bad, walk_more, adj_more, no_room, split_in_store;

	assign rd_used    = hdr_rd_data[ENTRY_W-1];
	assign rd_size    = hdr_rd_data[SIZE_W-1:0];
	assign rd_size_x  = OFF_W'(rd_size);
	assign heap_end_x = OFF_W'(heap_end_q);
	assign lim        = (heap_limit > LIM_CAP) ? LIM_CAP : heap_limit;

	assign fit   = !rd_used && (rd_size_x >= n_q);
	// sizes are multiples of 8, so "greater" means room for a header plus 8
	assign split = rd_size_x > nspan_q;
	assign free_bad = (addr_q == '0) || (addr_q[ALIGN_W-1:0] != '0) ||
		(OFF_W'(addr_q) < SPAN) || (OFF_W'(addr_q) > heap_end_x);
	// offsets are multiples of 8: cur + span + 8 <= end  <=>  cur + span < end
	assign walk_more      = alu_res < heap_end_x;
	assign adj_more       = adj_q < heap_end_x;
	assign no_room        = alu_res > OFF_W'(lim);
	assign split_in_store = split_off_q < STORE_END;

	// finish strobe toward the result register
	logic        fin_en;
	logic [ADDR_W-1:0] fin_paddr;
	status_t     fin_status;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_ALLOC) ? ST_ALLOC_START : ST_FREE_START;
				end
			end
			ST_ALLOC_START: state_d = (size_q == '0) ? ST_DONE : ST_ALLOC_PREP;
			ST_ALLOC_PREP:  state_d = ST_WALK_CHK;
			ST_WALK_CHK:    state_d = walk_more ? ST_WALK_RD : ST_APPEND_CHK;
			ST_WALK_RD: begin
				if (!fit) begin
					state_d = ST_WALK_CHK;
				end else begin
					state_d = split ? ST_SPLIT_ADDR : ST_DONE;
				end
			end
			ST_SPLIT_ADDR:  state_d = ST_SPLIT_WR;
			ST_SPLIT_WR:    state_d = ST_DONE;
			ST_APPEND_CHK:  state_d = no_room ? ST_DONE : ST_APPEND_PAY;
			ST_APPEND_PAY:  state_d = ST_DONE;
			ST_FREE_START:  state_d = free_bad ? ST_DONE : ST_FREE_HDR;
			ST_FREE_HDR:    state_d = ST_FREE_CHK;
			ST_FREE_CHK:    state_d = adj_more ? ST_FREE_NXT : ST_FREE_WR;
			ST_FREE_NXT:    state_d = rd_used ? ST_FREE_WR : ST_FREE_ACC;
			ST_FREE_ACC:    state_d = ST_FREE_CHK;
			ST_FREE_WR:     state_d = ST_DONE;
			ST_DONE:        state_d = res_ready ? ST_IDLE : ST_DONE;
			default:        state_d = ST_IDLE;
		endcase
	end

	// state outputs: adder operands, store access, finish strobe
	always_comb begin
		alu_a      = '0;
		alu_b      = '0;
		alu_sub    = 1'b0;
		hdr_req    = '0;
		in_ready   = 1'b0;
		res_valid  = 1'b0;
		fin_en     = 1'b0;
		fin_paddr  = '0;
		fin_status = STAT_OK;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_ALLOC_START: begin
				alu_a = OFF_W'(size_q);
				alu_b = ROUND_ADD;
				if (size_q == '0) begin
					fin_en     = 1'b1;
					fin_status = STAT_ZERO_SIZE;
				end
			end
			ST_ALLOC_PREP: begin
				alu_a = n_q;
				alu_b = SPAN;
			end
			ST_WALK_CHK: begin
				alu_a          = cur_q;
				alu_b          = SPAN;
				hdr_req.rd_en  = 1'b1;
				hdr_req.rd_off = cur_q;
			end
			ST_WALK_RD: begin
				alu_a = pay_q;
				alu_b = rd_size_x;
				if (fit) begin
					hdr_req.wr_en   = 1'b1;
					hdr_req.wr_off  = cur_q;
					hdr_req.wr_data = split ? {1'b1, n_q[SIZE_W-1:0]} : {1'b1, rd_size};
					if (!split) begin
						fin_en    = 1'b1;
						fin_paddr = pay_q[ADDR_W-1:0];
					end
				end
			end
			ST_SPLIT_ADDR: begin
				alu_a = pay_q;
				alu_b = n_q;
			end
			ST_SPLIT_WR: begin
				alu_a           = OFF_W'(ps_q);
				alu_b           = nspan_q;
				alu_sub         = 1'b1;
				// a remainder header beyond the store is dropped
				hdr_req.wr_en   = split_in_store;
				hdr_req.wr_off  = split_off_q;
				hdr_req.wr_data = {1'b0, alu_res[SIZE_W-1:0]};
				fin_en          = 1'b1;
				fin_paddr       = pay_q[ADDR_W-1:0];
			end
			ST_APPEND_CHK: begin
				alu_a = heap_end_x;
				alu_b = nspan_q;
				if (no_room) begin
					fin_en     = 1'b1;
					fin_status = STAT_NO_MEM;
				end else begin
					hdr_req.wr_en   = 1'b1;
					hdr_req.wr_off  = heap_end_x;
					hdr_req.wr_data = {1'b1, n_q[SIZE_W-1:0]};
				end
			end
			ST_APPEND_PAY: begin
				alu_a     = heap_end_x;
				alu_b     = SPAN;
				fin_en    = 1'b1;
				fin_paddr = alu_res[ADDR_W-1:0];
			end
			ST_FREE_START: begin
				alu_a   = OFF_W'(addr_q);
				alu_b   = SPAN;
				alu_sub = 1'b1;
				if (free_bad) begin
					fin_en     = 1'b1;
					fin_status = STAT_FREE_IGNORED;
				end else begin
					hdr_req.rd_en  = 1'b1;
					hdr_req.rd_off = alu_res;
				end
			end
			ST_FREE_HDR: begin
				alu_a = OFF_W'(addr_q);
				alu_b = rd_size_x;
			end
			ST_FREE_CHK: begin
				hdr_req.rd_en  = adj_more;
				hdr_req.rd_off = adj_q;
			end
			ST_FREE_NXT: begin
				alu_a = adj_q;
				alu_b = SPAN;
			end
			ST_FREE_ACC: begin
				alu_a = adj_q;
				alu_b = OFF_W'(sz_q);
			end
			ST_FREE_WR: begin
				// merged payload size = next header - own payload offset
				alu_a           = adj_q;
				alu_b           = OFF_W'(addr_q);
				alu_sub         = 1'b1;
				hdr_req.wr_en   = 1'b1;
				hdr_req.wr_off  = hdr_off_q;
				hdr_req.wr_data = {1'b0, alu_res[SIZE_W-1:0]};
				fin_en          = 1'b1;
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			heap_end_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_APPEND_PAY) begin
				heap_end_q <= new_end_q[LIMIT_W-1:0];
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					size_q <= size;
					addr_q <= addr;
				end
			end
			ST_ALLOC_START: n_q <= {alu_res[OFF_W-1:ALIGN_W], ALIGN_W'(0)};
			ST_ALLOC_PREP: begin
				nspan_q <= alu_res;
				cur_q   <= '0;
			end
			ST_WALK_CHK:   pay_q <= alu_res;
			ST_WALK_RD: begin
				cur_q <= alu_res;
				ps_q  <= rd_size;
			end
			ST_SPLIT_ADDR: split_off_q <= alu_res;
			ST_APPEND_CHK: new_end_q   <= alu_res;
			ST_FREE_START: hdr_off_q   <= alu_res;
			ST_FREE_HDR:   adj_q       <= alu_res;
			ST_FREE_NXT: begin
				// a block in use ends the run; adj_q stays on its header
				if (!rd_used) begin
					adj_q <= alu_res;
					sz_q  <= rd_size;
				end
			end
			ST_FREE_ACC:   adj_q       <= alu_res;
			default: begin
				adj_q <= adj_q;
			end
		endcase
		if (fin_en) begin
			res_paddr_q  <= fin_paddr;
			res_status_q <= fin_status;
		end
	end

	assign res_paddr  = res_paddr_q;
	assign res_status = res_status_q;

	// checks
	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(hdr_req.rd_en && hdr_req.wr_en))
		else $error("header store read and write in the same cycle");

	a_heap_end_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		heap_end_q[ALIGN_W-1:0] == '0)
		else $error("heap end off alignment");

	a_walk_rd_after_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_RD) |-> ($past(state_q) == ST_WALK_CHK))
		else $error("header evaluated without a read issued");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPEND_PAY) |=> (heap_end_q > $past(heap_end_q)))
		else $error("append did not grow the heap");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_status != STAT_OK)) |-> (res_paddr == '0))
		else $error("failed request returns an address");

endmodule : ffha_seq
`default_nettype wire

[rtl/first_fit_heap_allocator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core: first-fit heap allocator, top level
// Allocates and frees blocks of an implicit header list kept in an on-chip
// header store; holds the heap limit register and the result register.
// ----------------------------------------------------------------------------
// One request is worked at a time; in_ready is high only between requests.
// Timing depends on the list walk through the header store and the shared
// adder. Allocate rounds the size and adds the header span, then reads each
// block header in turn until one fits; a split writes the remainder header,
// and when no block fits the heap end is checked and extended if there is
// room. Free reads the block header, then absorbs each following free block
// until a block in use or the heap end. Zero-size allocate and ignored free
// finish without a header store access. A finished result waits in the
// output register while the next request is already being worked. The
// header store needs no clearing after reset.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// heap limit register
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	// request channel
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               op,
	input  wire logic [SIZE_W-1:0]  size,
	input  wire logic [ADDR_W-1:0]  addr,
	// result channel
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [ADDR_W-1:0]  payload_addr,
	output      logic [1:0]         status
);

	localparam int HDR_SPAN    = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
	localparam int STORE_BYTES = (HEAP_BYTES < MAX_STORE_BYTES) ? HEAP_BYTES : MAX_STORE_BYTES;
	localparam int SLOTS       = STORE_BYTES / ALIGN_BYTES;
	localparam int HEAP_LIM    = (HEAP_BYTES > LIMIT_MAX) ? LIMIT_MAX : HEAP_BYTES;

	logic [LIMIT_W-1:0] heap_limit_q;
	hdr_req_t           hdr_req;
	logic [ENTRY_W-1:0] hdr_rd_data;
	logic               res_valid, res_ready;
	logic [ADDR_W-1:0]  res_paddr;
	status_t            res_status;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  payload_addr_q;
	status_t            status_q;

	// heap limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			heap_limit_q <= cfg_wdata;
		end
	end

	ffha_hdr_ram #(
		.SLOTS(SLOTS)
	) u_hdr_ram (
		.clk    (clk),
		.req    (hdr_req),
		.rd_data(hdr_rd_data)
	);

	ffha_seq #(
		.HDR_SPAN   (HDR_SPAN),
		.STORE_BYTES(STORE_BYTES),
		.HEAP_LIM   (HEAP_LIM)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op_t'(op)),
		.size       (size),
		.addr       (addr),
		.heap_limit (heap_limit_q),
		.hdr_req    (hdr_req),
		.hdr_rd_data(hdr_rd_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_paddr  (res_paddr),
		.res_status (res_status)
	);

	// result register: loads when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			payload_addr_q <= res_paddr;
			status_q       <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_addr = payload_addr_q;
	assign status       = status_q;

endmodule : first_fit_heap_allocator_core
`default_nettype wire

[sim/tb_first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_core: self-checking bench for the heap allocator
// Drives allocate and free words with random sender bursts and receiver
// stalls. It keeps its own copy of the block list, heap end and heap limit,
// predicts each reply in request order and compares it field by field.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_core;
	import ffha_pkg::*;

	// header span rounded to the alignment, smallest payload, store depth
	localparam int unsigned SPAN      = ((HEADER_BYTES_DEF + ALIGN_BYTES - 1) / ALIGN_BYTES)
		* ALIGN_BYTES;
	localparam int unsigned MIN_PAY   = 8;
	localparam int unsigned HDR_SLOTS = HEAP_BYTES_DEF / ALIGN_BYTES;

	typedef struct packed {
		logic              used;
		logic [SIZE_W-1:0] bytes;
	} hdr_entry_t;

	typedef struct packed {
		logic [ADDR_W-1:0] paddr;
		status_t           st;
	} heap_reply_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_MOSTLY
	} ready_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = OP_ALLOC;
	logic [SIZE_W-1:0]  size = '0;
	logic [ADDR_W-1:0]  addr = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ADDR_W-1:0]  payload_addr;
	logic [1:0]         status;

	// shadow of the allocator state
	hdr_entry_t         hdr_store [HDR_SLOTS];
	bit                 hdr_written [HDR_SLOTS];
	logic [LIMIT_W-1:0] heap_top = '0;
	logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

	heap_reply_t        heap_replies [$];
	int unsigned        live_payloads [$];
	int unsigned        idle_payloads [$];
	int                 fault_count = 0;
	int                 burst_left = 0;
	int                 stall_hold = 0;
	int                 mode_left = 0;
	ready_mode_t        ready_mode = RDY_ALWAYS;

	first_fit_heap_allocator_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.size        (size),
		.addr        (addr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.payload_addr(payload_addr),
		.status      (status)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow allocator
	// ------------------------------------------------------------------------
	function automatic hdr_entry_t read_hdr(input int unsigned off);
		int unsigned idx;
		idx = off / ALIGN_BYTES;
		if (idx < HDR_SLOTS)
			return hdr_store[idx];
		return '0;
	endfunction

	function automatic void write_hdr(input int unsigned off, input logic used,
			input int unsigned bytes);
		int unsigned idx;
		idx = off / ALIGN_BYTES;
		if (idx < HDR_SLOTS) begin
			hdr_store[idx] = {used, SIZE_W'(bytes)};
			hdr_written[idx] = 1'b1;
		end
	endfunction

	// limit in force: register clamped to the heap size
	function automatic int unsigned heap_ceiling();
		return (limit_reg > HEAP_BYTES_DEF) ? HEAP_BYTES_DEF : limit_reg;
	endfunction

	function automatic heap_reply_t grant_alloc(input logic [SIZE_W-1:0] req_bytes);
		heap_reply_t r;
		hdr_entry_t  h;
		int unsigned need, cur, avail;
		r.paddr = '0;
		r.st = STAT_OK;
		if (req_bytes == 0) begin
			r.st = STAT_ZERO_SIZE;
			return r;
		end
		need = (32'(req_bytes) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
		// first fit walk from the heap start
		cur = 0;
		while (cur + SPAN + MIN_PAY <= heap_top) begin
			h = read_hdr(cur);
			avail = h.bytes;
			if (!h.used && avail >= need) begin
				if (avail >= need + SPAN + MIN_PAY) begin
					write_hdr(cur, 1'b1, need);
					write_hdr(cur + SPAN + need, 1'b0, avail - need - SPAN);
				end else begin
					write_hdr(cur, 1'b1, avail);
				end
				r.paddr = ADDR_W'(cur + SPAN);
				return r;
			end
			cur += SPAN + avail;
		end
		// nothing fits: grow the heap end
		if (heap_top + need + SPAN > heap_ceiling()) begin
			r.st = STAT_NO_MEM;
			return r;
		end
		write_hdr(heap_top, 1'b1, need);
		r.paddr = ADDR_W'(heap_top + SPAN);
		heap_top = LIMIT_W'(heap_top + need + SPAN);
		return r;
	endfunction

	function automatic status_t release_block(input logic [ADDR_W-1:0] a);
		int unsigned base, span_bytes, nxt;
		if (a == 0 || a % ALIGN_BYTES != 0 || a < SPAN || a > heap_top)
			return STAT_FREE_IGNORED;
		base = a - SPAN;
		span_bytes = read_hdr(base).bytes;
		nxt = base + SPAN + span_bytes;
		// absorb the free blocks that follow
		while (nxt < heap_top && !read_hdr(nxt).used) begin
			span_bytes += read_hdr(nxt).bytes + SPAN;
			nxt = base + SPAN + span_bytes;
		end
		write_hdr(base, 1'b0, span_bytes);
		return STAT_OK;
	endfunction

	function automatic heap_reply_t compute_heap_reply(input op_t req_op,
			input logic [SIZE_W-1:0] req_bytes, input logic [ADDR_W-1:0] req_addr);
		heap_reply_t r;
		if (req_op == OP_ALLOC) begin
			r = grant_alloc(req_bytes);
		end else begin
			r.paddr = '0;
			r.st = release_block(req_addr);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// true when a free of this address reads only entries already written
	// and leaves a size that fits the header field
	function automatic bit free_reads_known(input logic [ADDR_W-1:0] a);
		int unsigned base, span_bytes, nxt;
		if (a == 0 || a % ALIGN_BYTES != 0 || a < SPAN || a > heap_top)
			return 1'b1;
		base = a - SPAN;
		if (!hdr_written[base / ALIGN_BYTES])
			return 1'b0;
		span_bytes = hdr_store[base / ALIGN_BYTES].bytes;
		nxt = base + SPAN + span_bytes;
		while (nxt < heap_top) begin
			if (!hdr_written[nxt / ALIGN_BYTES])
				return 1'b0;
			if (hdr_store[nxt / ALIGN_BYTES].used)
				break;
			span_bytes += hdr_store[nxt / ALIGN_BYTES].bytes + SPAN;
			nxt = base + SPAN + span_bytes;
		end
		return span_bytes < (1 << SIZE_W);
	endfunction

	// payload offsets of the blocks on the list, split by in-use mark
	function automatic void scan_block_list();
		int unsigned cur;
		hdr_entry_t  h;
		live_payloads.delete();
		idle_payloads.delete();
		cur = 0;
		while (cur + SPAN + MIN_PAY <= heap_top) begin
			h = read_hdr(cur);
			if (h.used)
				live_payloads.push_back(cur + SPAN);
			else
				idle_payloads.push_back(cur + SPAN);
			cur += SPAN + h.bytes;
		end
	endfunction

	// one request word; valid is lowered only at the start of a gap
	task automatic send_request(input op_t req_op, input logic [SIZE_W-1:0] req_bytes,
			input logic [ADDR_W-1:0] req_addr);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= req_op;
		size <= req_bytes;
		addr <= req_addr;
		do @(posedge clk); while (!in_ready);
		heap_replies.push_back(compute_heap_reply(req_op, req_bytes, req_addr));
	endtask

	task automatic drain_requests();
		@(negedge clk);
		in_valid <= 1'b0;
		while (heap_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register written only with the block idle
	task automatic write_heap_limit(input logic [LIMIT_W-1:0] value);
		drain_requests();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		limit_reg = value;
	endtask

	// random allocate or free; frees mostly hit real blocks
	task automatic random_request(input int unsigned size_max);
		int unsigned       sel, pick;
		logic [SIZE_W-1:0] req_bytes;
		logic [ADDR_W-1:0] target;
		sel = $urandom_range(0, 99);
		if (sel < 52) begin
			pick = $urandom_range(0, 39);
			if (pick == 0)
				req_bytes = '0;
			else if (pick == 1)
				req_bytes = SIZE_W'($urandom);
			else
				req_bytes = SIZE_W'($urandom_range(1, size_max));
			send_request(OP_ALLOC, req_bytes, ADDR_W'($urandom));
		end else begin
			scan_block_list();
			pick = $urandom_range(0, 99);
			if (pick < 60 && live_payloads.size() != 0) begin
				target = ADDR_W'(live_payloads[$urandom_range(0, live_payloads.size() - 1)]);
			end else if (pick < 72 && idle_payloads.size() != 0) begin
				target = ADDR_W'(idle_payloads[$urandom_range(0, idle_payloads.size() - 1)]);
			end else if (pick < 90) begin
				// near the heap: stale headers, past the end, misaligned
				target = ADDR_W'($urandom_range(0, heap_top / ALIGN_BYTES + 2) * ALIGN_BYTES);
				if ($urandom_range(0, 3) == 0)
					target[ALIGN_W-1:0] = ALIGN_W'($urandom);
			end else begin
				target = ADDR_W'($urandom);
			end
			if (!free_reads_known(target))
				target = (live_payloads.size() != 0) ? ADDR_W'(live_payloads[0]) : '0;
			send_request(OP_FREE, SIZE_W'($urandom), target);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_request_corners();
		// zero size, oversize, ignored frees
		send_request(OP_ALLOC, '0, '1);
		send_request(OP_ALLOC, '1, '0);
		send_request(OP_ALLOC, SIZE_W'(65536), '0);
		send_request(OP_FREE, '1, '0);
		send_request(OP_FREE, '0, '1);
		send_request(OP_FREE, '0, ADDR_W'(24));
		// appends: rounding up to 8
		send_request(OP_ALLOC, SIZE_W'(1), '0);
		send_request(OP_ALLOC, SIZE_W'(9), '0);
		send_request(OP_ALLOC, SIZE_W'(100), '0);
		send_request(OP_ALLOC, SIZE_W'(8), '0);
		send_request(OP_FREE, '0, ADDR_W'(260));
		send_request(OP_FREE, '0, ADDR_W'(272));
		// reuse with split, then exact fit
		send_request(OP_FREE, '0, ADDR_W'(120));
		send_request(OP_ALLOC, SIZE_W'(40), '0);
		send_request(OP_ALLOC, SIZE_W'(32), '0);
		// frees, double free and merge chains
		send_request(OP_FREE, '0, ADDR_W'(72));
		send_request(OP_FREE, '0, ADDR_W'(120));
		send_request(OP_FREE, '0, ADDR_W'(72));
		send_request(OP_FREE, '0, ADDR_W'(192));
		send_request(OP_FREE, '0, ADDR_W'(32));
		// stale headers inside a merged block
		send_request(OP_FREE, '0, ADDR_W'(192));
		send_request(OP_FREE, '0, ADDR_W'(120));
		send_request(OP_ALLOC, SIZE_W'(8), '0);
	endtask

	task automatic test_limit_below_end();
		write_heap_limit('0);
		send_request(OP_ALLOC, SIZE_W'(1000), '0);
		send_request(OP_ALLOC, SIZE_W'(16), '0);
		repeat (60) random_request(64);
	endtask

	task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit_value,
			input int count, input int unsigned size_max);
		write_heap_limit(limit_value);
		repeat (count) random_request(size_max);
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_output_backpressure();
		drain_requests();
		stall_hold = 400;
		repeat (30) random_request(256);
	endtask

	// collapse the list into one free block, then fill the heap to the top
	task automatic test_heap_fill();
		int unsigned fill_bytes, fill_base;
		scan_block_list();
		for (int i = live_payloads.size() - 1; i >= 0; i--)
			send_request(OP_FREE, '0, ADDR_W'(live_payloads[i]));
		send_request(OP_FREE, '0, ADDR_W'(SPAN));
		write_heap_limit('1);
		fill_base = heap_top;
		fill_bytes = HEAP_BYTES_DEF - fill_base - SPAN;
		// one slot too many passes only an unclamped limit
		send_request(OP_ALLOC, SIZE_W'(fill_bytes + ALIGN_BYTES), '0);
		send_request(OP_ALLOC, SIZE_W'(fill_bytes), '0);
		send_request(OP_ALLOC, SIZE_W'(8), '0);
		send_request(OP_ALLOC, SIZE_W'(8), '0);
		send_request(OP_FREE, '0, ADDR_W'(fill_base + SPAN));
		send_request(OP_ALLOC, SIZE_W'(fill_bytes - 64), '0);
	endtask

	// ------------------------------------------------------------------------
	// Receiver stall pattern
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_hold != 0) begin
			out_ready <= 1'b0;
			stall_hold--;
		end else begin
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			case (ready_mode)
				RDY_ALWAYS: out_ready <= 1'b1;
				RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
				default:    out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Reply checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		heap_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (heap_replies.size() == 0) begin
				$display("%0t: reply with none expected: payload_addr %0d status %0d",
					$time, payload_addr, status);
				fault_count++;
			end else begin
				want = heap_replies.pop_front();
				if (payload_addr !== want.paddr) begin
					$display("%0t: payload_addr expected %0d actual %0d",
						$time, want.paddr, payload_addr);
					fault_count++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					fault_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		foreach (hdr_store[i])
			hdr_store[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_request_corners();
		test_limit_below_end();
		test_random_traffic(LIMIT_W'(1024), 250, 48);
		test_random_traffic(LIMIT_W'(4096), 300, 200);
		test_random_traffic(LIMIT_W'(16384), 280, 1024);
		test_output_backpressure();
		test_heap_fill();
		test_random_traffic(LIMIT_W'(LIMIT_MAX), 300, 3000);
		test_random_traffic(LIMIT_RESET, 200, 64);

		drain_requests();
		repeat (20) @(posedge clk);
		if (fault_count == 0 && heap_replies.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// hang guard, far beyond the longest walk times every stall
	initial begin
		#320_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
